// File: sv/abte_pkg.sv
// Package for the abbreviation token expander.
// Holds the expansion ROM, marker text, run tables, FSM/kind enums and
// controller/datapath structs. No dependencies.
`default_nettype none

package abte_pkg;

  localparam int MarkLen  = 11;
  localparam int RomLen   = 112;
  localparam int NumRuns  = 11;
  localparam int NumWords = 7;
  localparam int FirstWord = 4;

  localparam int PtrW = $clog2(RomLen);
  localparam int RunW = $clog2(NumRuns);
  localparam int MarkW = $clog2(MarkLen + 1);
  localparam int RemW = 5;

  localparam logic [7:0] CodeBang   = 8'h21;  // '!'
  localparam logic [7:0] CodeDriver = 8'h3E;  // '>'
  localparam logic [7:0] CodeIokit  = 8'h7C;  // '|'
  localparam logic [7:0] CodeSecur  = 8'h24;  // '$'
  localparam logic [7:0] CodeBase   = 8'h40;  // '@'
  localparam logic [7:0] CodeEll    = 8'h6C;  // 'l'

  // "loaded kext"
  localparam logic [7:0] MarkText [MarkLen] = '{
    8'h6C, 8'h6F, 8'h61, 8'h64, 8'h65, 8'h64, 8'h20, 8'h6B, 8'h65, 8'h78, 8'h74
  };

  // Word selector codes after '!': U A F S C B I
  localparam logic [7:0] WordCode [NumWords] = '{
    8'h55, 8'h41, 8'h46, 8'h53, 8'h43, 8'h42, 8'h49
  };

  // Runs 0..3 are package prefixes, 4..10 are words, in selector order.
  localparam logic [PtrW-1:0] RunStart [NumRuns] = '{
    7'd0, 7'd17, 7'd33, 7'd52, 7'd62, 7'd70, 7'd75, 7'd81, 7'd88, 7'd98, 7'd107
  };
  localparam logic [RemW-1:0] RunLen [NumRuns] = '{
    5'd17, 5'd16, 5'd19, 5'd10, 5'd8, 5'd5, 5'd6, 5'd7, 5'd10, 5'd9, 5'd5
  };

  localparam logic [7:0] ExpRom [RomLen] = '{
    // prefix 0
    8'h63, 8'h6F, 8'h6D, 8'h2E, 8'h61, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h2E,
    8'h64, 8'h72, 8'h69, 8'h76, 8'h65, 8'h72, 8'h2E,
    // prefix 1
    8'h63, 8'h6F, 8'h6D, 8'h2E, 8'h61, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h2E,
    8'h69, 8'h6F, 8'h6B, 8'h69, 8'h74, 8'h2E,
    // prefix 2
    8'h63, 8'h6F, 8'h6D, 8'h2E, 8'h61, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h2E,
    8'h73, 8'h65, 8'h63, 8'h75, 8'h72, 8'h69, 8'h74, 8'h79, 8'h2E,
    // prefix 3
    8'h63, 8'h6F, 8'h6D, 8'h2E, 8'h61, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h2E,
    // words
    8'h41, 8'h70, 8'h70, 8'h6C, 8'h65, 8'h55, 8'h53, 8'h42,
    8'h41, 8'h70, 8'h70, 8'h6C, 8'h65,
    8'h46, 8'h61, 8'h6D, 8'h69, 8'h6C, 8'h79,
    8'h53, 8'h74, 8'h6F, 8'h72, 8'h61, 8'h67, 8'h65,
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h72, 8'h6F, 8'h6C, 8'h6C, 8'h65, 8'h72,
    8'h42, 8'h6C, 8'h75, 8'h65, 8'h74, 8'h6F, 8'h6F, 8'h74, 8'h68,
    8'h49, 8'h6E, 8'h74, 8'h65, 8'h6C
  };

  typedef enum logic [1:0] {
    KindSingle,   // one byte out
    KindHold,     // bang held, nothing out
    KindRom,      // ROM run
    KindPair      // '!' then the byte
  } kind_e;

  typedef enum logic {
    StPass,
    StRun
  } state_e;

  typedef struct packed {
    logic accept;
    logic step;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  out_free;
    logic  rem_last;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/abte_in_if.sv
// Input channel of the abbreviation token expander: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface abte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       msg_last;

  modport source (output valid, in_byte, msg_last, input ready);
  modport sink   (input valid, in_byte, msg_last, output ready);
endinterface

`default_nettype wire

// File: sv/abte_out_if.sv
// Output channel of the abbreviation token expander: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface abte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       msg_end;

  modport source (output valid, out_byte, run_last, msg_end, input ready);
  modport sink   (input valid, out_byte, run_last, msg_end, output ready);
endinterface

`default_nettype wire

// File: sv/abbreviation_token_expander.sv
// Abbreviation token expander, top level.
// Results are registered: an item's result lands in the output register in the cycle after it is taken.
// Throughput: plain bytes one item per cycle while the output is free; a ROM run of N
// bytes (5..19) or a bang pair (2 bytes) holds the input until its last byte has gone
// into the output register; a held bang gives no result.
// Reset (rst_ni low, asynchronous) clears marker, bang and run state and empties the output.
`default_nettype none

module abbreviation_token_expander
  import abte_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  abte_in_if.sink    in_i,
  abte_out_if.source out_o
);

  // Controller and datapath talk only through these two structs.
  cmd_t cmd;
  sts_t sts;

  abte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath owns the output register, so the controller can take the next plain
  // item as the byte held there is taken.
  abte_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_i.in_byte),
    .msg_last_i  (in_i.msg_last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last),
    .msg_end_o   (out_o.msg_end),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// File: sv/abte_ctrl.sv
// Controller FSM: pass state takes items, run state walks a multi-byte run.
// Depends on abte_pkg.
`default_nettype none

module abte_ctrl
  import abte_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StPass;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StPass: begin
        if (in_valid_i && sts_i.out_free &&
            (sts_i.kind == KindRom || sts_i.kind == KindPair)) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (sts_i.out_free && sts_i.rem_last) begin
          state_d = StPass;
        end
      end
      default: state_d = StPass;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StPass: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
      end
      StRun: begin
        cmd_o.step = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/abte_dp.sv
// Datapath: marker tracking, code classification, run pointer and output register.
// Depends on abte_pkg.
`default_nettype none

module abte_dp
  import abte_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       msg_last_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            msg_end_o,
  input  cmd_t            cmd_i,
  output sts_t            sts_o
);

  logic [MarkW-1:0] mark_prog_q, mark_prog_d;
  logic             mark_seen_q, mark_seen_d;
  logic             bang_q, bang_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [7:0]       held_q, held_d;
  logic             pair_q, pair_d;
  logic             last_q, last_d;
  logic             oval_q, oval_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             orl_q, orl_d;
  logic             ome_q, ome_d;

  kind_e           kind;
  logic [RunW-1:0] run_sel;
  logic            word_hit;
  logic [RunW-1:0] word_sel;
  logic [MarkW-1:0] prog_next;
  logic            out_free;

  assign out_free = !oval_q || out_ready_i;

  // Word selector lookup after a held bang.
  always_comb begin
    word_hit = 1'b0;
    word_sel = '0;
    for (int i = 0; i < NumWords; i++) begin
      if (in_byte_i == WordCode[i]) begin
        word_hit = 1'b1;
        word_sel = RunW'(FirstWord + i);
      end
    end
  end

  always_comb begin
    kind    = KindSingle;
    run_sel = '0;
    if (!mark_seen_q) begin
      kind = KindSingle;
    end else if (bang_q) begin
      kind    = word_hit ? KindRom : KindPair;
      run_sel = word_sel;
    end else begin
      case (in_byte_i)
        CodeDriver: begin kind = KindRom; run_sel = RunW'(0); end
        CodeIokit:  begin kind = KindRom; run_sel = RunW'(1); end
        CodeSecur:  begin kind = KindRom; run_sel = RunW'(2); end
        CodeBase:   begin kind = KindRom; run_sel = RunW'(3); end
        CodeBang:   kind = msg_last_i ? KindSingle : KindHold;
        default:    kind = KindSingle;
      endcase
    end
  end

  // Marker match; a mismatch restarts, counting an 'l' as a first byte.
  always_comb begin
    if ((mark_prog_q < MarkW'(MarkLen)) &&
        (in_byte_i == MarkText[mark_prog_q[MarkW-1:0]])) begin
      prog_next = mark_prog_q + MarkW'(1);
    end else begin
      prog_next = (in_byte_i == CodeEll) ? MarkW'(1) : MarkW'(0);
    end
  end

  always_comb begin
    mark_prog_d = mark_prog_q;
    mark_seen_d = mark_seen_q;
    bang_d      = bang_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    held_d      = held_q;
    pair_d      = pair_q;
    last_d      = last_q;
    oval_d      = oval_q && !out_ready_i;
    obyte_d     = obyte_q;
    orl_d       = orl_q;
    ome_d       = ome_q;

    if (cmd_i.accept) begin
      last_d = msg_last_i;
      if (!mark_seen_q) begin
        mark_prog_d = prog_next;
        if (prog_next >= MarkW'(MarkLen)) begin
          mark_seen_d = 1'b1;
        end
      end else if (bang_q) begin
        bang_d = 1'b0;
      end else if (kind == KindHold) begin
        bang_d = 1'b1;
      end

      case (kind)
        KindSingle: begin
          oval_d  = 1'b1;
          obyte_d = in_byte_i;
          orl_d   = 1'b1;
          ome_d   = msg_last_i;
        end
        KindRom: begin
          oval_d  = 1'b1;
          obyte_d = ExpRom[RunStart[run_sel]];
          orl_d   = 1'b0;
          ome_d   = 1'b0;
          ptr_d   = RunStart[run_sel] + PtrW'(1);
          rem_d   = RunLen[run_sel] - RemW'(1);
          pair_d  = 1'b0;
        end
        KindPair: begin
          oval_d  = 1'b1;
          obyte_d = CodeBang;
          orl_d   = 1'b0;
          ome_d   = 1'b0;
          rem_d   = RemW'(1);
          held_d  = in_byte_i;
          pair_d  = 1'b1;
        end
        default: begin
          oval_d = oval_q && !out_ready_i;
        end
      endcase

      // End of message: marker and bang tracking state back to reset.
      if (msg_last_i) begin
        mark_prog_d = '0;
        mark_seen_d = 1'b0;
        bang_d      = 1'b0;
      end
    end else if (cmd_i.step) begin
      oval_d  = 1'b1;
      obyte_d = pair_q ? held_q : ExpRom[ptr_q];
      orl_d   = (rem_q == RemW'(1));
      ome_d   = (rem_q == RemW'(1)) && last_q;
      ptr_d   = ptr_q + PtrW'(1);
      rem_d   = rem_q - RemW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_prog_q <= '0;
      mark_seen_q <= 1'b0;
      bang_q      <= 1'b0;
      oval_q      <= 1'b0;
      rem_q       <= '0;
      pair_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      mark_prog_q <= mark_prog_d;
      mark_seen_q <= mark_seen_d;
      bang_q      <= bang_d;
      oval_q      <= oval_d;
      rem_q       <= rem_d;
      pair_q      <= pair_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    held_q  <= held_d;
    obyte_q <= obyte_d;
    orl_q   <= orl_d;
    ome_q   <= ome_d;
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign run_last_o  = orl_q;
  assign msg_end_o   = ome_q;

  assign sts_o.kind     = kind;
  assign sts_o.out_free = out_free;
  assign sts_o.rem_last = (rem_q == RemW'(1));

endmodule

`default_nettype wire
